// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ring FIFO with search.
// No dependencies; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RFS_ASSERT(lbl, clk, rst, prop, msg)
`define RFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rfs_pkg.sv =====
// Package for the ring FIFO with search: sizes, operation codes, CSR map,
// sequencer state type and the wrap-around pointer step. No dependencies.
`timescale 1ns / 1ps
package rfs_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int KIND_W = 2;
   localparam int POS_W  = 7;
   localparam int CAP_W  = 7;
   localparam int FILL_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // APB map: one 32-bit register per word address
   localparam int ADDR_W      = 3;
   localparam int PDATA_W     = 32;
   localparam int REG_SEL_W   = ADDR_W - 2;
   localparam logic [REG_SEL_W-1:0] REG_CAPACITY = REG_SEL_W'(0);

   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_POP   = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_CHECK = 4'b1000
   } state_type;

   // step a ring pointer, wrapping at the effective capacity
   function automatic logic [IDX_W-1:0] rfs_advance(input logic [IDX_W-1:0] idx,
                                                    input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      if (nxt >= cap) begin
         return '0;
      end
      return nxt[IDX_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/ring_fifo_with_search_unit.sv =====
// Ring FIFO of 32-bit words with a linear search, APB capacity register.
// Enqueue, rejects and unknown kinds: result in the cycle after start, 1 word/cycle.
// Dequeue: result registered via ST_POP and then the result register (registered RAM read), busy for 1 cycle.
// Search: each entry examined passes ST_FETCH (RAM read) then ST_CHECK (compare), from
//   head until a hit or the last entry; one RAM read port and one shared comparator.
// Synchronous reset clears pointers and count and sets capacity to 64; RAM is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ring_fifo_with_search_unit (
   input  logic                              clock,
   input  logic                              reset,
   // command side
   input  logic                              start,
   output logic                              busy,
   input  logic [rfs_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [rfs_pkg::WORD_W-1:0] req_value,
   // result side: one strobe per word, cannot be stalled
   output logic                              rsp_valid,
   output logic [0:0]                        rsp_status,
   output logic signed [rfs_pkg::WORD_W-1:0] rsp_data,
   output logic signed [rfs_pkg::POS_W-1:0]  rsp_position,
   output logic [rfs_pkg::FILL_W-1:0]        rsp_fill_count,
   // APB CSR port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rfs_pkg::ADDR_W-1:0]        paddr,
   input  logic [rfs_pkg::PDATA_W-1:0]       pwdata,
   output logic [rfs_pkg::PDATA_W-1:0]       prdata,
   output logic                              pready
);
   import rfs_pkg::*;

   // storage: single write port, single registered read port
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;   // RAM index being searched
   logic [IDX_W-1:0]  offset_ff, offset_in;       // offset of that entry from head
   logic [WORD_W-1:0] value_ff, value_in;         // search key

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [0:0]               rsp_status_ff, rsp_status_in;
   logic signed [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;

   logic [CNT_W-1:0]  cap_eff;
   logic              cfg_wr;
   logic              accept;
   logic              full;
   logic              last_entry;

   // capacity of zero acts as one, anything above DEPTH acts as DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1:2] == REG_CAPACITY);
   assign prdata  = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(cap_ff) : '0;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign full       = (count_ff >= cap_eff);
   assign last_entry = ((CNT_W'(offset_ff) + CNT_W'(1)) == count_ff);

   // search walks the RAM from scan_idx, everything else reads at head
   assign rd_addr = (state_ff == ST_FETCH) ? scan_idx_ff : head_ff;

   // sequencer and pointer updates
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      scan_idx_in   = scan_idx_ff;
      offset_in     = offset_ff;
      value_in      = value_ff;
      wr_en         = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_fill_in   = rsp_fill_ff;

      if (cfg_wr) begin
         // new capacity empties the queue
         cap_in   = pwdata[CAP_W-1:0];
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
         state_in = ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  value_in      = req_value;
                  rsp_status_in = 1'b0;
                  rsp_data_in   = '0;
                  rsp_pos_in    = '1;
                  rsp_fill_in   = FILL_W'(count_ff);
                  case (req_kind)
                     KIND_ENQUEUE: begin
                        rsp_valid_in = 1'b1;
                        if (full) begin
                           rsp_status_in = 1'b1;
                        end else begin
                           wr_en       = 1'b1;
                           tail_in     = rfs_advance(tail_ff, cap_eff);
                           count_in    = count_ff + CNT_W'(1);
                           rsp_fill_in = FILL_W'(count_ff + CNT_W'(1));
                        end
                     end
                     KIND_DEQUEUE: begin
                        if (count_ff == '0) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = 1'b1;
                        end else begin
                           // head word lands in rd_data_ff at this edge
                           state_in = ST_POP;
                        end
                     end
                     KIND_SEARCH: begin
                        if (count_ff == '0) begin
                           rsp_valid_in = 1'b1;
                        end else begin
                           scan_idx_in = head_ff;
                           offset_in   = '0;
                           state_in    = ST_FETCH;
                        end
                     end
                     default: begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                     end
                  endcase
               end
            end
            ST_POP: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data_ff;
               head_in      = rfs_advance(head_ff, cap_eff);
               count_in     = count_ff - CNT_W'(1);
               rsp_fill_in  = FILL_W'(count_ff - CNT_W'(1));
               state_in     = ST_IDLE;
            end
            ST_FETCH: begin
               state_in = ST_CHECK;
            end
            ST_CHECK: begin
               if (rd_data_ff == value_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_pos_in   = POS_W'(offset_ff);
                  state_in     = ST_IDLE;
               end else if (last_entry) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  scan_idx_in = rfs_advance(scan_idx_ff, cap_eff);
                  offset_in   = offset_ff + IDX_W'(1);
                  state_in    = ST_FETCH;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // RAM: no reset, only written entries are ever used
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= value_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      offset_ff     <= offset_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_fill_count = rsp_fill_ff;

   `RFS_ASSERT(a_count_le_cap, clock, reset, count_ff <= cap_eff, "fill count above capacity")
   `RFS_ASSERT(a_ptr_in_range, clock, reset, (CNT_W'(head_ff) < cap_eff) && (CNT_W'(tail_ff) < cap_eff), "pointer outside ring")
   `RFS_ASSERT(a_scan_bound, clock, reset, !((state_ff == ST_FETCH) || (state_ff == ST_CHECK)) || (CNT_W'(offset_ff) < count_ff), "search ran past stored entries")
   `RFS_ASSERT(a_rsp_when_idle, clock, reset, !rsp_valid_ff || (state_ff == ST_IDLE), "result word while sequencer busy")
   `RFS_ASSERT_NEXT(a_empty_pop_reject, clock, reset, accept && !cfg_wr && (req_kind == KIND_DEQUEUE) && (count_ff == '0), rsp_valid_ff && rsp_status_ff[0], "dequeue on empty not rejected at once")

endmodule
